>>> design/b64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, character codes and the symbol table of the Base64 line encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

   localparam logic [7:0] CHAR_CR        = 8'h0D;
   localparam logic [7:0] CHAR_LF        = 8'h0A;
   localparam logic [7:0] CHAR_PAD       = 8'h3D;
   localparam logic [7:0] MIN_LINE       = 8'd4;
   localparam logic [7:0] RESET_LINE_LEN = 8'd76;
   localparam logic       RESET_BREAKS   = 1'b1;

   localparam logic [0:0] REG_ADD_BREAKS = 1'b0;
   localparam logic [0:0] REG_LINE_LEN   = 1'b1;

   localparam logic [1:0] PHASE_0 = 2'd0;
   localparam logic [1:0] PHASE_1 = 2'd1;
   localparam logic [1:0] PHASE_2 = 2'd2;

   typedef struct packed {
      logic [3:0][7:0] chars;
      logic [1:0]      last_idx;
      logic            last;
   } job_type;

   typedef struct packed {
      logic       add_line_breaks;
      logic [7:0] line_length;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic in_break;
   } back_stat_type;

   typedef enum logic [1:0] {
      BK_CHAR,
      BK_CR,
      BK_LF
   } back_state_type;

   function automatic logic [7:0] b64_sym(input logic [5:0] v);
      logic [7:0] r;
      priority if (v < 6'd26) begin
         r = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         r = 8'h61 + ({2'b00, v} - 8'd26);
      end else if (v < 6'd62) begin
         r = 8'h30 + ({2'b00, v} - 8'd52);
      end else if (v == 6'd62) begin
         r = 8'h2B;
      end else begin
         r = 8'h2F;
      end
      return r;
   endfunction

endpackage
`default_nettype wire

>>> design/base64_encoder_line_wrap.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_encoder_line_wrap
// Base64 encoder with optional CR LF line wrapping, one byte in, one
// character out per transfer.
//
//   channel  ports   payload                       role
//   req      req_*   data_byte, last_byte          message bytes in
//   rsp      rsp_*   out_char, out_last            characters, pads, CR, LF out
//   csr      csr_*   add_line_breaks, line_length  APB-style register access
//
// The back end sends one character per cycle while rsp does not stall, and a
// byte gives one to four characters (1.33 on average) plus CR LF per break.
// Bytes are taken one per cycle while the job queue has room.
// Reset clears phase, column and queue; registers return to 1 and 76.
// A stall on rsp fills the queue and then holds req_ready low.
// ----------------------------------------------------------------------------
module base64_encoder_line_wrap #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_last_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_out_last,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import b64e_pkg::*;

   cfg_type        cfg_ff;
   logic           csr_wr;
   logic           push;
   job_type        push_job;
   logic           pop;
   logic           head_valid;
   job_type        head_job;
   q_stat_type     q_stat;
   back_stat_type  back_stat;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.add_line_breaks <= RESET_BREAKS;
         cfg_ff.line_length     <= RESET_LINE_LEN;
      end else if (csr_wr) begin
         unique case (csr_paddr[2:2])
            REG_ADD_BREAKS: cfg_ff.add_line_breaks <= csr_pwdata[0];
            REG_LINE_LEN:   cfg_ff.line_length     <= csr_pwdata[7:0];
            default:        cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2:2])
         REG_ADD_BREAKS: csr_prdata = {31'd0, cfg_ff.add_line_breaks};
         REG_LINE_LEN:   csr_prdata = {24'd0, cfg_ff.line_length};
         default:        csr_prdata = 32'd0;
      endcase
   end

   b64e_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_full        (q_stat.full),
      .push          (push),
      .push_job      (push_job)
   );

   b64e_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job),
      .stat       (q_stat)
   );

   b64e_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .head_valid   (head_valid),
      .head_job     (head_job),
      .pop          (pop),
      .stat         (back_stat),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

   a_cr_then_lf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (rsp_out_char == CHAR_CR)
      |=> rsp_valid && (rsp_out_char == CHAR_LF))
      else $error("CR transfer not followed by LF");

   a_break_holds_job: assert property (@(posedge clock) disable iff (reset)
      back_stat.in_break |-> !q_stat.empty)
      else $error("line break in progress with empty queue");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty at once");

endmodule
`default_nettype wire

>>> design/b64e_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_front
// Takes input bytes, tracks the 3-byte group phase and turns each byte into
// a job of one to four output characters.
// ----------------------------------------------------------------------------
module b64e_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [7:0]           req_data_byte,
   input  wire                  req_last_byte,
   input  wire                  q_full,
   output logic                 push,
   output b64e_pkg::job_type    push_job
);
   import b64e_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [5:0] left_ff, left_in;
   logic [5:0] new_left;

   assign req_ready = !q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      push_job.chars    = {4{CHAR_PAD}};
      push_job.last_idx = 2'd0;
      push_job.last     = req_last_byte;
      new_left          = 6'd0;
      phase_in          = phase_ff;
      left_in           = left_ff;
      unique case (phase_ff)
         PHASE_1: begin
            new_left          = {req_data_byte[3:0], 2'b00};
            push_job.chars[0] = b64_sym(left_ff | {2'b00, req_data_byte[7:4]});
            push_job.chars[1] = b64_sym(new_left);
            push_job.last_idx = req_last_byte ? 2'd2 : 2'd0;
            phase_in          = PHASE_2;
         end
         PHASE_2: begin
            push_job.chars[0] = b64_sym(left_ff | {4'b0000, req_data_byte[7:6]});
            push_job.chars[1] = b64_sym(req_data_byte[5:0]);
            push_job.last_idx = 2'd1;
            phase_in          = PHASE_0;
         end
         default: begin
            new_left          = {req_data_byte[1:0], 4'b0000};
            push_job.chars[0] = b64_sym(req_data_byte[7:2]);
            push_job.chars[1] = b64_sym(new_left);
            push_job.last_idx = req_last_byte ? 2'd3 : 2'd0;
            phase_in          = PHASE_1;
         end
      endcase
      left_in = new_left;
      if (req_last_byte) begin
         phase_in = PHASE_0;
         left_in  = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_0;
         left_ff  <= 6'd0;
      end else if (push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule
`default_nettype wire

>>> design/b64e_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_queue
// Small job queue between the byte front end and the character back end.
// ----------------------------------------------------------------------------
module b64e_queue #(
   parameter int DEPTH = 2
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  b64e_pkg::job_type      push_job,
   input  wire                    pop,
   output logic                   head_valid,
   output b64e_pkg::job_type      head_job,
   output b64e_pkg::q_stat_type   stat
);
   import b64e_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign stat.full  = (count_ff == FULL_CNT);
   assign stat.empty = (count_ff == '0);
   assign head_valid = !stat.empty;
   assign head_job   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

>>> design/b64e_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64e_back
// Sends queued characters one per cycle unless rsp_ready stalls, counts
// columns and inserts CR LF at each line end if add_line_breaks is set.
// ----------------------------------------------------------------------------
module b64e_back (
   input  wire                      clock,
   input  wire                      reset,
   input  b64e_pkg::cfg_type        cfg,
   input  wire                      head_valid,
   input  b64e_pkg::job_type        head_job,
   output logic                     pop,
   output b64e_pkg::back_stat_type  stat,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   output logic [7:0]               rsp_out_char,
   output logic                     rsp_out_last
);
   import b64e_pkg::*;

   back_state_type state_ff, state_in;
   logic [1:0]     idx_ff, idx_in;
   logic [7:0]     col_ff, col_in;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_char_ff;
   logic           rsp_last_ff;

   logic [7:0] len_eff;
   logic [7:0] col_inc;
   logic       brk;
   logic       at_end;
   logic       adv;
   logic       load;
   logic [7:0] char_sel;
   logic       last_sel;

   assign len_eff  = (cfg.line_length < MIN_LINE) ? MIN_LINE : cfg.line_length;
   assign col_inc  = col_ff + 8'd1;
   assign brk      = cfg.add_line_breaks && (col_inc >= len_eff);
   assign at_end   = (idx_ff == head_job.last_idx);
   assign adv      = !rsp_valid_ff || rsp_ready;

   assign stat.in_break = (state_ff != BK_CHAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_out_last  = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CHAR: if (adv && head_valid && brk) state_in = BK_CR;
         BK_CR:   if (adv) state_in = BK_LF;
         BK_LF:   if (adv) state_in = BK_CHAR;
         default: state_in = BK_CHAR;
      endcase
   end

   always_comb begin
      load     = 1'b0;
      char_sel = head_job.chars[idx_ff];
      last_sel = 1'b0;
      pop      = 1'b0;
      idx_in   = idx_ff;
      col_in   = col_ff;
      unique case (state_ff)
         BK_CHAR: begin
            if (adv && head_valid) begin
               load = 1'b1;
               if (cfg.add_line_breaks) begin
                  col_in = brk ? 8'd0 : col_inc;
               end
               if (!brk) begin
                  if (at_end) begin
                     pop      = 1'b1;
                     idx_in   = 2'd0;
                     last_sel = head_job.last;
                     if (head_job.last) col_in = 8'd0;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
            end
         end
         BK_CR: begin
            char_sel = CHAR_CR;
            load     = adv;
         end
         BK_LF: begin
            char_sel = CHAR_LF;
            if (adv) begin
               load = 1'b1;
               if (at_end) begin
                  pop      = 1'b1;
                  idx_in   = 2'd0;
                  last_sel = head_job.last;
                  if (head_job.last) col_in = 8'd0;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CHAR;
         idx_ff       <= 2'd0;
         col_ff       <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         col_ff   <= col_in;
         if (adv) rsp_valid_ff <= load;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_char_ff <= char_sel;
         rsp_last_ff <= last_sel;
      end
   end

endmodule
`default_nettype wire
